@@ design/bss_pkg.sv @@
// ----------------------------------------------------------------------------
// bss_pkg
// shared codes, register widths, reset values and types of the balance
// safety supervisor
// ----------------------------------------------------------------------------
package bss_pkg;

  // default widths of the pitch and tick counter
  localparam int PitchBitsDef = 16;
  localparam int TickBitsDef  = 16;

  // configuration register widths
  localparam int FallThrW   = 15;
  localparam int ArmWinW    = 15;
  localparam int LimitW     = 8;
  localparam int DeadlineW  = 16;
  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FALL_THR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ARM_WIN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEADLINE = 2'd3;

  // configuration reset values
  localparam logic [FallThrW-1:0]  FallThrRst  = 15'd6434;
  localparam logic [ArmWinW-1:0]   ArmWinRst   = 15'd1024;
  localparam logic [LimitW-1:0]    LimitRst    = 8'd3;
  localparam logic [DeadlineW-1:0] DeadlineRst = 16'd100;

  // event opcodes
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_ESTIMATE  = 3'd1;
  localparam logic [2:0] OP_ARM       = 3'd2;
  localparam logic [2:0] OP_DISARM    = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_CALIBRATE = 3'd5;

  // supervisor modes
  localparam logic [2:0] MODE_INIT  = 3'd0;
  localparam logic [2:0] MODE_CAL   = 3'd1;
  localparam logic [2:0] MODE_IDLE  = 3'd2;
  localparam logic [2:0] MODE_ARMED = 3'd3;
  localparam logic [2:0] MODE_FAULT = 3'd4;

  // fault causes
  localparam logic [2:0] CAUSE_NONE     = 3'd0;
  localparam logic [2:0] CAUSE_EST_INV  = 3'd1;
  localparam logic [2:0] CAUSE_FALL     = 3'd2;
  localparam logic [2:0] CAUSE_DRIVER   = 3'd3;
  localparam logic [2:0] CAUSE_STALLED  = 3'd4;
  localparam logic [2:0] CAUSE_SELFTEST = 3'd5;
  localparam logic [2:0] CAUSE_CALIB    = 3'd6;

  // sensor calibration status
  localparam logic [1:0] CAL_BUSY   = 2'd0;
  localparam logic [1:0] CAL_DONE   = 2'd1;
  localparam logic [1:0] CAL_FAILED = 2'd2;

  typedef struct packed {
    logic [FallThrW-1:0]  fall_thr;
    logic [ArmWinW-1:0]   arm_win;
    logic [LimitW-1:0]    limit;
    logic [DeadlineW-1:0] deadline;
  } bss_cfg_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [2:0]        cause;
    logic              serviced;
    logic [LimitW-1:0] missed;
    logic              last_valid;
  } bss_ctl_t;

  typedef struct packed {
    logic       est_valid;
    logic       drv_fault;
    logic       drv_ready;
    logic       sampling;
    logic [1:0] cal_status;
  } bss_flags_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] mode_now;
    logic [2:0] fault_cause;
    logic       drive_permitted;
    logic       disable_drive;
    logic       clear_driver_fault;
    logic       start_calibration;
    logic       reset_balancer;
    logic       run_balance;
  } bss_res_t;

endpackage

@@ design/balance_safety_supervisor.sv @@
// ----------------------------------------------------------------------------
// balance_safety_supervisor
// safety supervisor for a balancing motor drive: mode, fault latch, service
// watchdog, self-test deadline and command pulses toward driver, sensor and
// balancer
// ----------------------------------------------------------------------------
// Each accepted event word (tick, estimate, arm, disarm, clear fault,
// calibrate) yields exactly one result word. An event is captured in the input
// register, then, once the result register is free or drains, a single
// combinational step updates mode, fault cause, service flag, missed-service
// counter, tick count and stored estimate, and loads the result register.
// One event per cycle is sustained while the result side takes every word,
// set by that one step stage. The input side takes a word while its register
// is empty, or when the held event steps because the result register is free
// or drains in the same cycle. Configuration writes are registered, with no
// read-back; writing the missed-service limit leaves the missed-service
// counter as it is. There is no clearing pass after reset. Pitch magnitude
// saturates at the largest positive pitch value.
module balance_safety_supervisor #(
  parameter int PITCH_BITS = bss_pkg::PitchBitsDef,
  parameter int TICK_BITS  = bss_pkg::TickBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [bss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bss_pkg::CfgDataW-1:0] cfg_wdata_i,
  // event word
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   opcode_i,
  input  logic [PITCH_BITS-1:0]        pitch_i,
  input  logic                         estimate_valid_i,
  input  logic                         driver_fault_i,
  input  logic                         driver_ready_i,
  input  logic                         sensing_sampling_i,
  input  logic [1:0]                   calibration_status_i,
  // result word
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         accepted_o,
  output logic [2:0]                   mode_now_o,
  output logic [2:0]                   fault_cause_o,
  output logic                         drive_permitted_o,
  output logic                         disable_drive_o,
  output logic                         clear_driver_fault_o,
  output logic                         start_calibration_o,
  output logic                         reset_balancer_o,
  output logic                         run_balance_o
);
  import bss_pkg::*;

  // configuration registers
  bss_cfg_t              cfg_q;

  // input register
  logic                  in_valid_q;
  logic [2:0]            opcode_q;
  logic [PITCH_BITS-1:0] pitch_q;
  bss_flags_t            flags_q;

  // supervisor state
  bss_ctl_t              ctl_q, ctl_d;
  logic [PITCH_BITS-1:0] last_pitch_q, last_pitch_d;
  logic [TICK_BITS-1:0]  ticks_q, ticks_d;

  // result register
  logic                  out_valid_q;
  bss_res_t              res_q, res_d;

  logic                  step_fire;

  // the step runs when an event is held and the result register can take it
  assign step_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_fire;

  // configuration writes, write data truncated to register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fall_thr <= FallThrRst;
      cfg_q.arm_win  <= ArmWinRst;
      cfg_q.limit    <= LimitRst;
      cfg_q.deadline <= DeadlineRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FALL_THR: cfg_q.fall_thr <= cfg_wdata_i[FallThrW-1:0];
        CFG_ARM_WIN:  cfg_q.arm_win  <= cfg_wdata_i[ArmWinW-1:0];
        CFG_LIMIT:    cfg_q.limit    <= cfg_wdata_i[LimitW-1:0];
        CFG_DEADLINE: cfg_q.deadline <= cfg_wdata_i[DeadlineW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      opcode_q           <= opcode_i;
      pitch_q            <= pitch_i;
      flags_q.est_valid  <= estimate_valid_i;
      flags_q.drv_fault  <= driver_fault_i;
      flags_q.drv_ready  <= driver_ready_i;
      flags_q.sampling   <= sensing_sampling_i;
      flags_q.cal_status <= calibration_status_i;
    end
  end

  bss_step #(
    .PITCH_BITS (PITCH_BITS),
    .TICK_BITS  (TICK_BITS)
  ) u_step (
    .cfg_i        (cfg_q),
    .ctl_i        (ctl_q),
    .last_pitch_i (last_pitch_q),
    .ticks_i      (ticks_q),
    .opcode_i     (opcode_q),
    .pitch_i      (pitch_q),
    .flags_i      (flags_q),
    .ctl_o        (ctl_d),
    .last_pitch_o (last_pitch_d),
    .ticks_o      (ticks_d),
    .res_o        (res_d)
  );

  // supervisor state, missed counter starts at the reset limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.mode       <= MODE_INIT;
      ctl_q.cause      <= CAUSE_NONE;
      ctl_q.serviced   <= 1'b0;
      ctl_q.missed     <= LimitRst;
      ctl_q.last_valid <= 1'b0;
      last_pitch_q     <= '0;
      ticks_q          <= '0;
    end else if (step_fire) begin
      ctl_q        <= ctl_d;
      last_pitch_q <= last_pitch_d;
      ticks_q      <= ticks_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign accepted_o           = res_q.accepted;
  assign mode_now_o           = res_q.mode_now;
  assign fault_cause_o        = res_q.fault_cause;
  assign drive_permitted_o    = res_q.drive_permitted;
  assign disable_drive_o      = res_q.disable_drive;
  assign clear_driver_fault_o = res_q.clear_driver_fault;
  assign start_calibration_o  = res_q.start_calibration;
  assign reset_balancer_o     = res_q.reset_balancer;
  assign run_balance_o        = res_q.run_balance;

`ifndef SYNTHESIS
  // a latched cause exists exactly while in fault
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.mode == MODE_FAULT) == (ctl_q.cause != CAUSE_NONE))
    else $error("fault mode and latched cause disagree");

  // fault is left only by an accepted clear-fault event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_q.mode == MODE_FAULT) && !(step_fire && opcode_q == OP_CLEAR)
    |=> ctl_q.mode == MODE_FAULT)
    else $error("fault mode left without clear-fault");

  // the balancer only runs while armed, never together with a shutdown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && run_balance_o |-> mode_now_o == MODE_ARMED && !disable_drive_o)
    else $error("balance run outside armed mode");

  // tick count never wraps back to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ticks_q != '0 |=> ticks_q != '0)
    else $error("tick count wrapped");
`endif

endmodule

@@ design/bss_step.sv @@
// ----------------------------------------------------------------------------
// bss_step
// next state and result of the supervisor for one event
// ----------------------------------------------------------------------------
module bss_step #(
  parameter int PITCH_BITS = bss_pkg::PitchBitsDef,
  parameter int TICK_BITS  = bss_pkg::TickBitsDef
) (
  input  bss_pkg::bss_cfg_t   cfg_i,
  input  bss_pkg::bss_ctl_t   ctl_i,
  input  logic [PITCH_BITS-1:0] last_pitch_i,
  input  logic [TICK_BITS-1:0]  ticks_i,
  input  logic [2:0]            opcode_i,
  input  logic [PITCH_BITS-1:0] pitch_i,
  input  bss_pkg::bss_flags_t flags_i,
  output bss_pkg::bss_ctl_t   ctl_o,
  output logic [PITCH_BITS-1:0] last_pitch_o,
  output logic [TICK_BITS-1:0]  ticks_o,
  output bss_pkg::bss_res_t   res_o
);
  import bss_pkg::*;

  localparam int MagW     = PITCH_BITS - 1;
  localparam int CmpW     = (MagW > FallThrW) ? MagW : FallThrW;
  localparam int TickCmpW = (TICK_BITS > DeadlineW) ? TICK_BITS : DeadlineW;

  // |p| saturated at the largest positive value
  function automatic logic [MagW-1:0] pitch_mag(input logic [PITCH_BITS-1:0] p);
    logic [PITCH_BITS-1:0] neg;
    logic [MagW-1:0]       mag;
    neg = (~p) + {{(PITCH_BITS-1){1'b0}}, 1'b1};
    if (!p[PITCH_BITS-1]) begin
      mag = p[MagW-1:0];
    end else if (p[MagW-1:0] == '0) begin
      mag = '1;
    end else begin
      mag = neg[MagW-1:0];
    end
    return mag;
  endfunction

  logic [MagW-1:0]      est_mag;
  logic [MagW-1:0]      last_mag;
  logic                 too_steep;
  logic                 arm_level;
  logic [TICK_BITS-1:0] ticks_inc;
  logic                 deadline_hit;
  logic [LimitW-1:0]    missed_next;
  logic                 fault_hit;
  logic [2:0]           fault_code;
  bss_ctl_t             ctl;
  bss_res_t             res;

  assign est_mag   = pitch_mag(pitch_i);
  assign last_mag  = pitch_mag(last_pitch_i);
  assign too_steep = CmpW'(est_mag) > CmpW'(cfg_i.fall_thr);
  assign arm_level = CmpW'(last_mag) <= CmpW'(cfg_i.arm_win);

  // saturating tick count
  assign ticks_inc    = (ticks_i != '1) ? ticks_i + {{(TICK_BITS-1){1'b0}}, 1'b1} : ticks_i;
  assign deadline_hit = TickCmpW'(ticks_inc) >= TickCmpW'(cfg_i.deadline);

  // service check
  always_comb begin
    if (ctl_i.serviced) begin
      missed_next = '0;
    end else if (ctl_i.missed < cfg_i.limit) begin
      missed_next = ctl_i.missed + 8'd1;
    end else begin
      missed_next = ctl_i.missed;
    end
  end

  always_comb begin
    ctl          = ctl_i;
    last_pitch_o = last_pitch_i;
    ticks_o      = ticks_i;
    res          = '0;
    fault_hit    = 1'b0;
    fault_code   = CAUSE_NONE;

    unique case (opcode_i)
      OP_TICK: begin
        ticks_o = ticks_inc;
        if (ctl_i.mode == MODE_INIT) begin
          if (flags_i.drv_ready && flags_i.sampling) begin
            res.start_calibration = 1'b1;
            ctl.mode              = MODE_CAL;
          end else if (deadline_hit) begin
            fault_hit  = 1'b1;
            fault_code = CAUSE_SELFTEST;
          end
        end else if (ctl_i.mode == MODE_CAL) begin
          if (flags_i.cal_status == CAL_DONE) begin
            ctl.mode = MODE_IDLE;
          end else if (flags_i.cal_status == CAL_FAILED) begin
            fault_hit  = 1'b1;
            fault_code = CAUSE_CALIB;
          end
        end else if (ctl_i.mode == MODE_IDLE || ctl_i.mode == MODE_ARMED) begin
          if (flags_i.drv_fault) begin
            fault_hit  = 1'b1;
            fault_code = CAUSE_DRIVER;
          end else begin
            ctl.missed   = missed_next;
            ctl.serviced = 1'b0;
            if (ctl_i.mode == MODE_ARMED && missed_next >= cfg_i.limit) begin
              fault_hit  = 1'b1;
              fault_code = CAUSE_STALLED;
            end
          end
        end
      end
      OP_ESTIMATE: begin
        ctl.serviced   = 1'b1;
        ctl.last_valid = flags_i.est_valid;
        last_pitch_o   = pitch_i;
        if (ctl_i.mode == MODE_ARMED) begin
          if (!flags_i.est_valid) begin
            fault_hit  = 1'b1;
            fault_code = CAUSE_EST_INV;
          end else if (too_steep) begin
            fault_hit  = 1'b1;
            fault_code = CAUSE_FALL;
          end else if (flags_i.drv_fault) begin
            fault_hit  = 1'b1;
            fault_code = CAUSE_DRIVER;
          end else begin
            res.run_balance = 1'b1;
          end
        end
      end
      OP_ARM: begin
        if (ctl_i.mode == MODE_IDLE && ctl_i.last_valid && arm_level &&
            (ctl_i.serviced || ctl_i.missed == '0) &&
            flags_i.drv_ready && !flags_i.drv_fault) begin
          res.reset_balancer = 1'b1;
          res.accepted       = 1'b1;
          ctl.mode           = MODE_ARMED;
        end
      end
      OP_DISARM: begin
        if (ctl_i.mode == MODE_ARMED) begin
          res.disable_drive = 1'b1;
          res.accepted      = 1'b1;
          ctl.mode          = MODE_IDLE;
        end
      end
      OP_CLEAR: begin
        if (ctl_i.mode == MODE_FAULT) begin
          res.clear_driver_fault = 1'b1;
          res.accepted           = 1'b1;
          ctl.cause              = CAUSE_NONE;
          ctl.mode               = MODE_IDLE;
        end
      end
      OP_CALIBRATE: begin
        if (ctl_i.mode == MODE_IDLE) begin
          res.start_calibration = 1'b1;
          res.accepted          = 1'b1;
          ctl.mode              = MODE_CAL;
        end
      end
      default: begin
        // unused opcodes only report status
      end
    endcase

    if (fault_hit) begin
      res.disable_drive = 1'b1;
      ctl.cause         = fault_code;
      ctl.mode          = MODE_FAULT;
    end

    res.mode_now        = ctl.mode;
    res.fault_cause     = ctl.cause;
    res.drive_permitted = (ctl.mode == MODE_ARMED);
  end

  assign ctl_o = ctl;
  assign res_o = res;

endmodule
